>>> hdl/srtsd_pkg.sv
// ----------------------------------------------------------------------------
// Sorted record table package
// Request, result and record types, action codes and status codes shared by
// the sorted record table and anything that drives it.
// ----------------------------------------------------------------------------
`default_nettype none

package srtsd_pkg;

    localparam int KEY_W    = 31;
    localparam int HALF_W   = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [HALF_W-1:0]   free_slots_in;
        logic [HALF_W-1:0]   fee_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [HALF_W-1:0]   free_slots_out;
        logic [HALF_W-1:0]   fee_out;
        logic [COUNT_W-1:0]  entry_count;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HALF_W-1:0] free_slots;
        logic [HALF_W-1:0] fee;
    } rec_t;

endpackage

`default_nettype wire

>>> hdl/sorted_record_table_search_delete.sv
// ----------------------------------------------------------------------------
// Sorted record table with binary search and shift delete
// Holds up to DEPTH records in descending key order in a single-port-read,
// single-port-write memory, and runs append, search, delete and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and exactly one
// result follows, shown for a single cycle with done high; the receiver
// cannot stall it and must take it in that cycle. Append and clear leave busy
// low, and their result appears in the cycle after the request. Search is
// a binary search in which every probe is one memory read in ST_PROBE and
// one key comparison in ST_CMP. On a match, delete then moves every record
// above the matched one down by one address in ST_SHIFT, reading one record
// and writing the one read before it, so the memory moves one record per
// cycle, and then lowers the entry count. Busy stays high for the whole of a
// search or delete.
`default_nettype none

module sorted_record_table_search_delete #(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire srtsd_pkg::req_t  req,
    output logic                  done,
    output srtsd_pkg::res_t       result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_SHIFT
    } state_t;

    srtsd_pkg::rec_t mem [DEPTH];
    srtsd_pkg::rec_t rd_data_reg;

    state_t          state_reg,    state_next;
    logic [CW-1:0]   count_reg,    count_next;
    logic [CW-1:0]   lo_reg,       lo_next;
    logic [CW-1:0]   hi1_reg,      hi1_next;
    logic [CW-1:0]   mid_reg,      mid_next;
    logic [CW-1:0]   ptr_reg,      ptr_next;
    logic [AW-1:0]   wr_addr_reg,  wr_addr_next;
    logic            pend_reg,     pend_next;
    logic            delete_reg,   delete_next;
    logic [srtsd_pkg::KEY_W-1:0] key_reg, key_next;
    logic            done_reg,     done_next;
    srtsd_pkg::res_t res_reg,      res_next;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    srtsd_pkg::rec_t mem_wd;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [CW:0]     mid_sum;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CW+1)'(1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi1_next     = hi1_reg;
        mid_next     = mid_reg;
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        delete_next  = delete_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    key_next = req.key;
                    case (req.action)
                        srtsd_pkg::ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                res_next.status      = srtsd_pkg::STAT_FULL;
                                res_next.entry_count = srtsd_pkg::COUNT_W'(count_reg);
                            end
                            else
                            begin
                                mem_we                  = 1'b1;
                                mem_wa                  = count_reg[AW-1:0];
                                mem_wd.key              = req.key;
                                mem_wd.free_slots       = req.free_slots_in;
                                mem_wd.fee              = req.fee_in;
                                count_next              = count_reg + CW'(1);
                                res_next.status         = srtsd_pkg::STAT_OK;
                                res_next.position       = srtsd_pkg::POS_W'(count_reg);
                                res_next.free_slots_out = req.free_slots_in;
                                res_next.fee_out        = req.fee_in;
                                res_next.entry_count    =
                                    srtsd_pkg::COUNT_W'(count_reg + CW'(1));
                            end
                        end
                        srtsd_pkg::ACT_SEARCH,
                        srtsd_pkg::ACT_DELETE:
                        begin
                            delete_next = (req.action == srtsd_pkg::ACT_DELETE);
                            lo_next     = '0;
                            hi1_next    = count_reg;
                            state_next  = ST_PROBE;
                        end
                        default:
                        begin
                            count_next           = '0;
                            res_next.status      = srtsd_pkg::STAT_OK;
                            res_next.entry_count = '0;
                            done_next            = 1'b1;
                        end
                    endcase
                end
            end

            ST_PROBE:
            begin
                if (lo_reg < hi1_reg)
                begin
                    mid_next   = mid_sum[CW:1];
                    rd_en      = 1'b1;
                    rd_addr    = mid_sum[AW:1];
                    state_next = ST_CMP;
                end
                else
                begin
                    res_next.status      = srtsd_pkg::STAT_NOT_FOUND;
                    res_next.entry_count = srtsd_pkg::COUNT_W'(count_reg);
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_CMP:
            begin
                if (rd_data_reg.key == key_reg)
                begin
                    res_next.status         = srtsd_pkg::STAT_OK;
                    res_next.position       = srtsd_pkg::POS_W'(mid_reg);
                    res_next.free_slots_out = rd_data_reg.free_slots;
                    res_next.fee_out        = rd_data_reg.fee;
                    if (delete_reg)
                    begin
                        ptr_next   = mid_reg + CW'(1);
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        res_next.entry_count = srtsd_pkg::COUNT_W'(count_reg);
                        done_next            = 1'b1;
                        state_next           = ST_IDLE;
                    end
                end
                else if (rd_data_reg.key > key_reg)
                begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = ST_PROBE;
                end
                else
                begin
                    hi1_next   = mid_reg;
                    state_next = ST_PROBE;
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = wr_addr_reg;
                    mem_wd = rd_data_reg;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = ptr_reg[AW-1:0];
                    wr_addr_next = AW'(ptr_reg - CW'(1));
                    ptr_next     = ptr_reg + CW'(1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next           = count_reg - CW'(1);
                        res_next.entry_count =
                            srtsd_pkg::COUNT_W'(count_reg - CW'(1));
                        done_next            = 1'b1;
                        state_next           = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            delete_reg  <= 1'b0;
            lo_reg      <= '0;
            hi1_reg     <= '0;
            mid_reg     <= '0;
            ptr_reg     <= '0;
            wr_addr_reg <= '0;
            key_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            pend_reg    <= pend_next;
            delete_reg  <= delete_next;
            lo_reg      <= lo_next;
            hi1_reg     <= hi1_next;
            mid_reg     <= mid_next;
            ptr_reg     <= ptr_next;
            wr_addr_reg <= wr_addr_next;
            key_reg     <= key_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire
